### sv/ffh_pkg.sv
// shared types and constants for the fault formation height map
// no dependencies
`default_nettype none
package ffh_pkg;
    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_FAULT  = 2'd1;
    localparam logic [1:0] ACT_SMOOTH = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    localparam logic [1:0] REG_MIN   = 2'd0;
    localparam logic [1:0] REG_MAX   = 2'd1;
    localparam logic [1:0] REG_ITER  = 2'd2;
    localparam logic [1:0] REG_COEFF = 2'd3;

    localparam int CELL_W = 32;

    // map edge length, matches the six-bit coordinate fields
    localparam int TERRAIN_SIZE = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HMUL,
        ST_HSTART,
        ST_HDIV,
        ST_FRD,
        ST_FWR,
        ST_SFIRST,
        ST_SRD,
        ST_SMUL,
        ST_SWR,
        ST_RRD,
        ST_RWAIT,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

### sv/fault_formation_heightmap.sv
// fault formation height map with four-pass one-pole smoothing, top level
// depends on ffh_pkg and ffh_divider
//
// channel | direction | contents
// s_axis  | in        | tdata: action, first_x, first_z, second_x, second_z, cell_x, cell_z
// m_axis  | out       | tdata: cell_height, faults_done
// cfg     | in        | wr_en, wr_index, wr_data
//
// clear: one cell written per cycle through the single map port
// fault: the height from one multiply and a 48-step divider, then each cell read and written back on the positive side
// smooth: 4 passes of N lines, per line a first-cell read (ST_SFIRST), then ST_SRD, ST_SMUL, ST_SWR per cell
// read: the cell is read in ST_RRD and ST_RWAIT; after reset a clear sweep runs with no result
// not ready while an item runs or a result waits; results held until taken
`default_nettype none
module fault_formation_heightmap
    import ffh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0], first_x, first_z, second_x, second_z, cell_x, cell_z (6 each), 2 zero bits
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // cell_height[31:0], faults_done[47:32]
    output logic [47:0]      m_axis_tdata,
    input  wire logic        wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [23:0] wr_data
);
    localparam int AW    = $clog2(TERRAIN_SIZE);
    localparam int DEPTH = TERRAIN_SIZE * TERRAIN_SIZE;
    localparam int MA    = 2 * AW;

    logic signed [CELL_W-1:0] mem [DEPTH];

    logic [23:0] min_reg, max_reg;
    logic [15:0] iter_reg, coeff_reg;
    logic [15:0] cnt_reg;
    state_t state_reg, state_next;

    logic        boot_reg;
    logic [5:0]  p1x_reg, p1z_reg, p2x_reg, p2z_reg, cx_reg, cz_reg;
    logic [AW-1:0] x_reg, z_reg;
    logic [1:0]  pass_reg;
    logic signed [47:0] h_reg;
    logic signed [CELL_W-1:0] rd_reg, prev_reg, res_reg;
    logic signed [63:0] acc_reg;
    logic               neg_reg;
    logic [MA-1:0] addr;
    logic          we;
    logic signed [CELL_W-1:0] wdata;

    logic        div_start, div_done;
    logic [47:0] div_q;
    logic signed [47:0] span_reg;
    logic [23:0] span_mag;
    logic [47:0] prod_reg;

    assign span_mag = span_reg[47] ? 24'(-span_reg) : span_reg[23:0];

    // line position mapping for the four passes
    logic [AW-1:0] pos, cx_map, cz_map;
    logic horiz;
    assign horiz = !pass_reg[1];
    assign pos   = pass_reg[0] ? AW'(TERRAIN_SIZE - 1) - x_reg : x_reg;
    assign cx_map = horiz ? pos : z_reg;
    assign cz_map = horiz ? z_reg : pos;

    ffh_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(prod_reg), .divisor(iter_reg == 16'd0 ? 16'd1 : iter_reg),
        .done(div_done), .quotient(div_q)
    );

    // cross product on small signed values
    logic signed [7:0] dxv, dzv, rx, rz;
    logic signed [16:0] cp;
    assign dxv = $signed({2'b0, p2x_reg}) - $signed({2'b0, p1x_reg});
    assign dzv = $signed({2'b0, p2z_reg}) - $signed({2'b0, p1z_reg});
    assign rx  = $signed({1'b0, 7'(x_reg)}) - $signed({2'b0, p1x_reg});
    assign rz  = $signed({1'b0, 7'(z_reg)}) - $signed({2'b0, p1z_reg});
    assign cp  = 17'(rx) * 17'(dzv) - 17'(dxv) * 17'(rz);

    // saturating add of the fault height
    logic signed [48:0] fsum;
    logic signed [CELL_W-1:0] fsat;
    assign fsum = 49'(rd_reg) + 49'(h_reg);
    always_comb
    begin
        if (fsum > 49'sd2147483647)       fsat = 32'sh7FFFFFFF;
        else if (fsum < -49'sd2147483648) fsat = 32'sh80000000;
        else                              fsat = fsum[31:0];
    end

    // blend: floor of acc / 32768, acc fits in 47 bits so no saturation reaches
    logic [16:0] fc;
    assign fc = (coeff_reg > 16'd32768) ? 17'd32768 : {1'b0, coeff_reg};
    logic signed [CELL_W-1:0] blend;
    assign blend = acc_reg[46:15];

    // f*prev + (32768-f)*cur rewritten as cur*32768 + f*(prev-cur)
    logic signed [32:0] sdiff;
    logic signed [49:0] sprod;
    assign sdiff = 33'(prev_reg) - 33'(rd_reg);
    assign sprod = $signed({1'b0, fc}) * sdiff;

    logic last_x, last_z;
    assign last_x = (x_reg == AW'(TERRAIN_SIZE - 1));
    assign last_z = (z_reg == AW'(TERRAIN_SIZE - 1));

    logic s_fire, m_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {cnt_reg, res_reg};

    always_comb
    begin
        state_next = state_reg;
        addr  = {z_reg, x_reg};
        we    = 1'b0;
        wdata = fsat;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_axis_tdata[1:0])
                        ACT_CLEAR:  state_next = ST_CLEAR;
                        ACT_FAULT:  state_next = ST_HMUL;
                        ACT_SMOOTH: state_next = ST_SFIRST;
                        default:    state_next = ST_RRD;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                wdata = '0;
                // the sweep after reset gives no result
                if (last_x && last_z) state_next = boot_reg ? ST_IDLE : ST_OUT;
            end
            ST_HMUL:  state_next = ST_HSTART;
            ST_HSTART:
            begin
                div_start = 1'b1;
                state_next = ST_HDIV;
            end
            ST_HDIV:  if (div_done) state_next = ST_FRD;
            ST_FRD:   state_next = ST_FWR;
            ST_FWR:
            begin
                we = (cp > 17'sd0);
                state_next = (last_x && last_z) ? ST_OUT : ST_FRD;
            end
            ST_SFIRST:
            begin
                addr = {cz_map, cx_map};
                state_next = ST_SRD;
            end
            ST_SRD:
            begin
                addr = {cz_map, cx_map};
                state_next = ST_SMUL;
            end
            ST_SMUL:  state_next = ST_SWR;
            ST_SWR:
            begin
                addr = {cz_map, cx_map};
                we = 1'b1;
                wdata = blend;
                if (!last_x) state_next = ST_SRD;
                else if (!last_z) state_next = ST_SFIRST;
                else if (pass_reg != 2'd3) state_next = ST_SFIRST;
                else state_next = ST_OUT;
            end
            ST_RRD:
            begin
                addr = {cz_reg[AW-1:0], cx_reg[AW-1:0]};
                state_next = ST_RWAIT;
            end
            ST_RWAIT: state_next = ST_OUT;
            ST_OUT:   if (m_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we) mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            boot_reg  <= 1'b1;
            min_reg   <= '0;
            max_reg   <= 24'd65536;
            iter_reg  <= 16'd100;
            coeff_reg <= 16'd24576;
            cnt_reg   <= '0;
            x_reg     <= '0;
            z_reg     <= '0;
            pass_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                case (wr_index)
                    REG_MIN:   min_reg   <= wr_data;
                    REG_MAX:   max_reg   <= wr_data;
                    REG_ITER:  iter_reg  <= wr_data[15:0];
                    REG_COEFF: coeff_reg <= wr_data[15:0];
                    default:   ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    x_reg <= '0;
                    z_reg <= '0;
                    pass_reg <= '0;
                    res_reg <= '0;
                    if (s_fire && s_axis_tdata[1:0] == ACT_CLEAR) cnt_reg <= '0;
                end
                ST_CLEAR, ST_FWR:
                begin
                    x_reg <= x_reg + AW'(1);
                    if (last_x) z_reg <= z_reg + AW'(1);
                    if (state_reg == ST_CLEAR && last_x && last_z) boot_reg <= 1'b0;
                    if (state_reg == ST_FWR && last_x && last_z && cnt_reg != 16'hFFFF)
                        cnt_reg <= cnt_reg + 16'd1;
                end
                ST_SFIRST: x_reg <= AW'(1);
                ST_SWR:
                begin
                    x_reg <= x_reg + AW'(1);
                    if (last_x)
                    begin
                        z_reg <= z_reg + AW'(1);
                        if (last_z) pass_reg <= pass_reg + 2'd1;
                    end
                end
                // six-bit coordinates always land inside the map
                ST_RWAIT: res_reg <= rd_reg;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                p1x_reg <= s_axis_tdata[7:2];
                p1z_reg <= s_axis_tdata[13:8];
                p2x_reg <= s_axis_tdata[19:14];
                p2z_reg <= s_axis_tdata[25:20];
                cx_reg  <= s_axis_tdata[31:26];
                cz_reg  <= s_axis_tdata[37:32];
                span_reg <= 48'(signed'(max_reg)) - 48'(signed'(min_reg));
            end
            ST_HMUL:
            begin
                neg_reg  <= span_reg[47];
                prod_reg <= 48'(cnt_reg) * 48'(span_mag);
            end
            ST_HDIV:
                if (div_done)
                    h_reg <= 48'(signed'(max_reg)) -
                             (neg_reg ? -$signed(div_q) : $signed(div_q));
            ST_SFIRST, ST_SWR: prev_reg <= (state_reg == ST_SWR) ? blend : prev_reg;
            ST_SMUL:
                acc_reg <= (64'(rd_reg) <<< 15) + 64'(sprod);
            default: ;
        endcase
        if (state_reg == ST_SRD && x_reg == AW'(1)) prev_reg <= rd_reg;
    end
endmodule
`default_nettype wire

### sv/ffh_divider.sv
// restoring divider, one quotient bit per cycle, unsigned 48 by 16 bits
// depends on nothing
`default_nettype none
module ffh_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [47:0]      quotient
);
    logic [47:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;

    assign trial    = {rem_reg[15:0], quo_reg[47]};
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd48;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= trial - {1'b0, div_reg};
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire
